// ----- src/slm_pkg.sv -----
// shared types, constants and the closure function of the line matcher
// no dependencies; used by every module and by the input and configuration interfaces
package slm_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int POS_W        = MAX_ELEMENTS + 1;
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int CHAR_W       = 8;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int CHAR_REGS    = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_0   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_1   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_2   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_3   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR    = 8'd7;

  // anchor_mode bits
  localparam int ANCHOR_START_BIT = 0;
  localparam int ANCHOR_END_BIT   = 1;

  typedef struct packed {
    logic [MAX_ELEMENTS-1:0][CHAR_W-1:0] chars;
    logic [MAX_ELEMENTS-1:0]             wild;
    logic [MAX_ELEMENTS-1:0]             rep_n;
    logic [MAX_ELEMENTS-1:0]             below_n;
    logic [POS_W-1:0]                    accept;
    logic                                start_anchor;
    logic                                end_anchor;
  } slm_cfg_t;

  typedef struct packed {
    logic [MAX_ELEMENTS-1:0] hit;
    logic                    last;
  } slm_word_t;

  // add every position reached by skipping starred elements; the carry
  // chain of one add propagates through runs of starred elements
  function automatic logic [POS_W-1:0] slm_close(input logic [POS_W-1:0] s,
                                                 input logic [MAX_ELEMENTS-1:0] rep);
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] carries;
    x       = s & {1'b0, rep};
    y       = {1'b0, rep};
    carries = (x + y) ^ x ^ y;
    return s | carries;
  endfunction

endpackage

// ----- src/slm_in_if.sv -----
// input channel of the line matcher: one text byte per word
// depends on slm_pkg for the byte width
interface slm_in_if;
  import slm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_byte;
  logic              end_of_line;

  modport source (output valid, output text_byte, output end_of_line, input ready);
  modport sink   (input valid, input text_byte, input end_of_line, output ready);
endinterface

// ----- src/slm_out_if.sv -----
// result channel of the line matcher: one match flag per line
// no dependencies
interface slm_out_if;
  logic valid;
  logic ready;
  logic line_matched;

  modport source (output valid, output line_matched, input ready);
  modport sink   (input valid, input line_matched, output ready);
endinterface

// ----- src/slm_cfg_if.sv -----
// configuration write channel of the line matcher
// depends on slm_pkg for index and data widths
interface slm_cfg_if;
  import slm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/slm_front.sv -----
// front end: takes text bytes and classifies them against every element
// depends on slm_pkg and slm_in_if
module slm_front (
  slm_in_if.sink               in_if,
  input  slm_pkg::slm_cfg_t    cfg,
  input  logic                 queue_full,
  output logic                 push,
  output slm_pkg::slm_word_t   push_word
);
  import slm_pkg::*;

  logic [MAX_ELEMENTS-1:0] hit;

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      hit[i] = cfg.wild[i] || (cfg.chars[i] == in_if.text_byte);
    end
  end

  assign in_if.ready    = !queue_full;
  assign push           = in_if.valid && !queue_full;
  assign push_word.hit  = hit;
  assign push_word.last = in_if.end_of_line;

endmodule

// ----- src/slm_queue.sv -----
// short queue of classified words between front and back end
// depends on slm_pkg
module slm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  slm_pkg::slm_word_t   push_word,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output slm_pkg::slm_word_t   head_word
);
  import slm_pkg::*;

  slm_word_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_word  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
`endif

endmodule

// ----- src/slm_back.sv -----
// back end: bit-parallel position update, line end finish and result register
// depends on slm_pkg and slm_out_if
module slm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slm_pkg::slm_cfg_t    cfg,
  input  logic                 head_valid,
  input  slm_pkg::slm_word_t   head_word,
  output logic                 pop,
  slm_out_if.source            out_if
);
  import slm_pkg::*;

  logic [POS_W-1:0]        live_r, live_nxt;
  logic                    at_start_r, at_start_nxt;
  logic                    match_r, match_nxt;
  logic                    fin_valid_r, fin_valid_nxt;
  logic [POS_W-1:0]        fin_set_r;
  logic                    fin_match_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_matched_r;

  logic                    fin_move;
  logic                    a_fire;
  logic [POS_W-1:0]        keep_mask;
  logic [POS_W-1:0]        set_c;
  logic [MAX_ELEMENTS-1:0] act;
  logic [POS_W-1:0]        raw;
  logic                    seed;
  logic                    step_match;
  logic [POS_W-1:0]        fin_closed;
  logic                    fin_result;

  assign fin_move = fin_valid_r && (!out_valid_r || out_if.ready);
  // a last byte waits until the finish slot frees up
  assign a_fire   = head_valid && (!head_word.last || !fin_valid_r || fin_move);
  assign pop      = a_fire;

  assign keep_mask  = cfg.accept | {1'b0, cfg.below_n};
  assign seed       = !cfg.start_anchor || at_start_r;
  assign set_c      = slm_close((live_r & keep_mask) | POS_W'(seed), cfg.rep_n);
  assign step_match = !cfg.end_anchor && ((set_c & cfg.accept) != '0);
  assign act        = set_c[MAX_ELEMENTS-1:0] & head_word.hit & cfg.below_n;
  // starred elements stay put, others move one position on
  assign raw        = {1'b0, act & cfg.rep_n} | {act & ~cfg.rep_n, 1'b0};

  // line end: one more start unless anchored, then check the accept position
  assign fin_closed = slm_close(fin_set_r | POS_W'(!cfg.start_anchor), cfg.rep_n);
  assign fin_result = fin_match_r || ((fin_closed & cfg.accept) != '0);

  always_comb begin
    live_nxt      = live_r;
    at_start_nxt  = at_start_r;
    match_nxt     = match_r;
    fin_valid_nxt = fin_valid_r;
    out_valid_nxt = out_valid_r;
    if (fin_move) begin
      fin_valid_nxt = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (a_fire) begin
      if (head_word.last) begin
        live_nxt      = '0;
        at_start_nxt  = 1'b1;
        match_nxt     = 1'b0;
        fin_valid_nxt = 1'b1;
      end else begin
        live_nxt     = raw;
        at_start_nxt = 1'b0;
        match_nxt    = match_r || step_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      at_start_r  <= 1'b1;
      match_r     <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      live_r      <= live_nxt;
      at_start_r  <= at_start_nxt;
      match_r     <= match_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && head_word.last) begin
      fin_set_r   <= raw;
      fin_match_r <= match_r || step_match;
    end
    if (fin_move) begin
      out_matched_r <= fin_result;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.line_matched = out_matched_r;

`ifndef SYNTHESIS
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && head_word.last |=> at_start_r && live_r == '0 && !match_r)
    else $error("state not cleared after line end");

  a_fin_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && head_word.last |=> fin_valid_r)
    else $error("line end lost before finish stage");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid_r && !fin_move |=> fin_valid_r && $stable(fin_match_r))
    else $error("stalled finish stage changed");
`endif

endmodule

// ----- src/simple_regex_line_matcher_unit.sv -----
// a line's result word passes the finish stage and then the result register
// throughput: one text byte per cycle while the queue is not full; the live position
// set closes its loop through one 17-bit carry chain in the back end each cycle
// synchronous active-low reset clears the configuration, the queue and the line state
// holds the configuration registers; depends on slm_pkg, the three channel
// interfaces, slm_front, slm_queue and slm_back
module simple_regex_line_matcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  slm_in_if.sink     in_if,
  slm_out_if.source  out_if,
  slm_cfg_if.sink    cfg_if
);
  import slm_pkg::*;

  logic [CHAR_REGS-1:0][CFG_DATA_W-1:0] chars_r;
  logic [MAX_ELEMENTS-1:0]              wild_r;
  logic [MAX_ELEMENTS-1:0]              rep_r;
  logic [LEN_W-1:0]                     len_r;
  logic [1:0]                           anchor_r;

  logic [LEN_W-1:0]  n_used;
  logic [POS_W-1:0]  accept;
  logic [POS_W-1:0]  below_full;
  slm_cfg_t          cfg;

  logic              push;
  slm_word_t         push_word;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  slm_word_t         head_word;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r  <= '0;
      wild_r   <= '0;
      rep_r    <= '0;
      len_r    <= '0;
      anchor_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index) inside
        CFG_CHARS_0, CFG_CHARS_1, CFG_CHARS_2, CFG_CHARS_3: begin
          chars_r[cfg_if.index[1:0]] <= cfg_if.data;
        end
        CFG_WILDCARD: wild_r   <= cfg_if.data[MAX_ELEMENTS-1:0];
        CFG_REPEAT:   rep_r    <= cfg_if.data[MAX_ELEMENTS-1:0];
        CFG_LENGTH:   len_r    <= cfg_if.data[LEN_W-1:0];
        CFG_ANCHOR:   anchor_r <= cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

  // lengths above the element count clamp to it
  assign n_used     = (len_r > LEN_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS) : len_r;
  assign accept     = POS_W'(1) << n_used;
  assign below_full = accept - POS_W'(1);

  always_comb begin
    cfg.chars        = chars_r;
    cfg.wild         = wild_r;
    cfg.below_n      = below_full[MAX_ELEMENTS-1:0];
    cfg.rep_n        = rep_r & below_full[MAX_ELEMENTS-1:0];
    cfg.accept       = accept;
    cfg.start_anchor = anchor_r[ANCHOR_START_BIT];
    cfg.end_anchor   = anchor_r[ANCHOR_END_BIT];
  end

  slm_front u_front (
    .in_if      (in_if),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_word  (push_word)
  );

  slm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  slm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_if     (out_if)
  );

endmodule
